@@ rtl/core/wsdf_pkg.sv @@
`default_nettype none
package wsdf_pkg;

	localparam int unsigned LIM_W = 25;
	localparam int unsigned LEN_W = 64;
	localparam int unsigned BURST_N = 6;
	localparam int unsigned CNT_W = 3;
	localparam logic [LIM_W-1:0] LIM_RESET = 25'd1048576;

	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_BIN = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING = 4'h9;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [7:0] PONG_HDR0 = 8'h8A;
	localparam logic [7:0] MASK_BIT = 8'h80;

	typedef enum logic [2:0] {
		KIND_PAYLOAD = 3'd0,
		KIND_EMPTY_END = 3'd1,
		KIND_TX = 3'd2,
		KIND_ERROR = 3'd3,
		KIND_DISCARD = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_LINK = 2'd1,
		ERR_LENGTH = 2'd2,
		ERR_CLOSE = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT = 3'd2,
		PH_MASK = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_HALT = 3'd5
	} phase_t;

	typedef struct packed {
		logic mode;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic message_end;
		logic last;
		logic [1:0] error_code;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/core/websocket_frame_deframer.sv @@
// WebSocket (RFC 6455) frame parser taking one link byte per request. A byte is
// accepted every cycle while the result buffer is empty or drains its last entry
// in that cycle; each byte is parsed into up to six results (a ping header yields
// six pong header bytes) that leave one per cycle while the result channel does
// not stall; the input stalls while a burst holds more than one result. Payload
// bytes stream through at one per cycle unless the result channel stalls. The
// limit register max_message_bytes resets to 1 MiB; the user must write it only
// while the block is idle; it is not enforced. Any error latches until reset.
`default_nettype none
module websocket_frame_deframer
	import wsdf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire req_t in_req,
	output logic out_valid,
	input wire logic out_stall,
	output res_t out_res,
	input wire logic cfg_we,
	input wire logic [LIM_W-1:0] cfg_data
);

	logic [LIM_W-1:0] lim_q;
	phase_t phase_q, phase_d;
	logic [3:0] ext_q, ext_d;
	logic fin_q, fin_d;
	logic [3:0] op_q, op_d;
	logic mask_q, mask_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [31:0] mb_q, mb_d;
	logic [1:0] pos_q, pos_d;
	logic [LIM_W-1:0] msg_q, msg_d;
	logic inm_q, inm_d;
	logic err_q, err_d;

	res_t burst_q [BURST_N];
	logic [CNT_W-1:0] cnt_q;
	res_t res [BURST_N];
	logic [CNT_W-1:0] nres;

	logic acc, pop, load;
	logic [7:0] b, v;
	logic lk, hd, over, fin_pay, is_data;

	assign acc = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign in_stall = !((cnt_q == '0) || (cnt_q == CNT_W'(1) && !out_stall));
	assign out_valid = (cnt_q != '0);
	assign out_res = burst_q[0];
	assign b = in_req.rx_byte;
	assign load = acc && (nres != '0);

	always_comb begin
		phase_d = phase_q;
		ext_d = ext_q;
		fin_d = fin_q;
		op_d = op_q;
		mask_d = mask_q;
		len_d = len_q;
		mb_d = mb_q;
		pos_d = pos_q;
		msg_d = msg_q;
		inm_d = inm_q;
		err_d = err_q;
		nres = '0;
		lk = 1'b0;
		hd = 1'b0;
		over = 1'b0;
		fin_pay = 1'b0;
		is_data = 1'b0;
		v = '0;
		for (int i = 0; i < BURST_N; i++) res[i] = '0;
		if (acc && !err_q && phase_q != PH_HALT) begin
			if (in_req.mode) begin
				err_d = 1'b1;
				phase_d = PH_HALT;
				res[0].kind = KIND_ERROR;
				res[0].error_code = ERR_LINK;
				nres = CNT_W'(1);
			end else begin
				unique case (phase_q)
					PH_HDR0: begin
						fin_d = b[7];
						op_d = b[3:0];
						phase_d = PH_HDR1;
					end
					PH_HDR1: begin
						mask_d = b[7];
						len_d = '0;
						if (b[6:0] == LEN_EXT16) begin
							ext_d = 4'd2;
							phase_d = PH_EXT;
						end else if (b[6:0] == LEN_EXT64) begin
							ext_d = 4'd8;
							phase_d = PH_EXT;
						end else begin
							len_d = LEN_W'(b[6:0]);
							lk = 1'b1;
						end
					end
					PH_EXT: begin
						len_d = {len_q[LEN_W-9:0], b};
						ext_d = ext_q - 4'd1;
						lk = (ext_q == 4'd1);
					end
					PH_MASK: begin
						mb_d = {mb_q[23:0], b};
						ext_d = ext_q - 4'd1;
						hd = (ext_q == 4'd1);
					end
					PH_PAYLOAD: begin
						v = b ^ mb_q[8*(3-pos_q) +: 8];
						fin_pay = (len_q == LEN_W'(1));
						is_data = (op_q == OP_TEXT) || (op_q == OP_BIN)
							|| (op_q == OP_CONT && inm_q);
						if (is_data) begin
							msg_d = msg_q + LIM_W'(1);
							res[0].kind = KIND_PAYLOAD;
							res[0].data_byte = v;
							res[0].message_end = fin_pay && fin_q;
							nres = CNT_W'(1);
							if (fin_pay && fin_q) begin
								inm_d = 1'b0;
								msg_d = '0;
							end
						end else if (op_q == OP_PING) begin
							res[0].kind = KIND_TX;
							res[0].data_byte = v;
							nres = CNT_W'(1);
						end
						pos_d = pos_q + 2'd1;
						len_d = len_q - LEN_W'(1);
						if (fin_pay) phase_d = PH_HDR0;
					end
					default: begin
					end
				endcase
				if (lk) begin
					over = (len_d > LEN_W'(lim_q)) || ((LEN_W'(msg_q) + len_d) > LEN_W'(lim_q));
					if (over) begin
						err_d = 1'b1;
						phase_d = PH_HALT;
						res[0].kind = KIND_ERROR;
						res[0].error_code = ERR_LENGTH;
						nres = CNT_W'(1);
					end else if (mask_d) begin
						ext_d = 4'd4;
						mb_d = '0;
						phase_d = PH_MASK;
					end else begin
						mb_d = '0;
						hd = 1'b1;
					end
				end
				if (hd) begin
					if (op_d == OP_CLOSE) begin
						err_d = 1'b1;
						phase_d = PH_HALT;
						res[0].kind = KIND_ERROR;
						res[0].error_code = ERR_CLOSE;
						nres = CNT_W'(1);
					end else begin
						if (op_d == OP_TEXT || op_d == OP_BIN) begin
							if (inm_q) begin
								res[0].kind = KIND_DISCARD;
								nres = CNT_W'(1);
							end
							msg_d = '0;
							inm_d = 1'b1;
						end
						if (op_d == OP_PING) begin
							for (int i = 0; i < BURST_N; i++) res[i].kind = KIND_TX;
							res[0].data_byte = PONG_HDR0;
							res[1].data_byte = MASK_BIT | {1'b0, len_d[6:0]};
							nres = CNT_W'(BURST_N);
						end
						if (len_d == '0) begin
							if (((op_d == OP_TEXT) || (op_d == OP_BIN)
								|| (op_d == OP_CONT && inm_d)) && fin_d) begin
								res[nres].kind = KIND_EMPTY_END;
								nres = nres + CNT_W'(1);
								inm_d = 1'b0;
								msg_d = '0;
							end
							phase_d = PH_HDR0;
						end else begin
							pos_d = '0;
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
		end
		for (int i = 0; i < BURST_N; i++) begin
			if (CNT_W'(i + 1) == nres) res[i].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_RESET;
			phase_q <= PH_HDR0;
			ext_q <= '0;
			fin_q <= 1'b0;
			op_q <= '0;
			mask_q <= 1'b0;
			len_q <= '0;
			mb_q <= '0;
			pos_q <= '0;
			msg_q <= '0;
			inm_q <= 1'b0;
			err_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) lim_q <= cfg_data;
			phase_q <= phase_d;
			ext_q <= ext_d;
			fin_q <= fin_d;
			op_q <= op_d;
			mask_q <= mask_d;
			len_q <= len_d;
			mb_q <= mb_d;
			pos_q <= pos_d;
			msg_q <= msg_d;
			inm_q <= inm_d;
			err_q <= err_d;
			if (load) cnt_q <= nres;
			else if (pop) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < BURST_N; i++) burst_q[i] <= res[i];
		end else if (pop) begin
			for (int i = 0; i < BURST_N - 1; i++) burst_q[i] <= burst_q[i+1];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BURST_N)) else $error("burst count out of range");
	a_no_res_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !load) else $error("result after latched error");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.kind == KIND_ERROR |-> out_res.error_code != ERR_NONE)
		else $error("error result without code");
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> phase_q == PH_HALT) else $error("latched error without halt");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q > CNT_W'(1) |-> in_stall) else $error("accept while burst pending");

endmodule
`default_nettype wire

@@ tb/websocket_frame_deframer_chk.sv @@
`timescale 1ns / 100ps
`default_nettype none
module websocket_frame_deframer_chk
	import wsdf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire req_t in_req,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire res_t out_res,
	input wire logic cfg_we,
	input wire logic [LIM_W-1:0] cfg_data,
	output int fail_count,
	output int pending
);

	res_t want_q[$];

	logic [LIM_W-1:0] p_limit;
	phase_t p_phase;
	logic [2:0] p_cnt;
	logic p_fin;
	logic [3:0] p_op;
	logic p_maskp;
	logic [63:0] p_len;
	logic [31:0] p_mask;
	logic [63:0] p_pos;
	logic [LIM_W-1:0] p_msg;
	logic p_inmsg;
	logic p_err;
	res_t burst[$];

	assign pending = want_q.size();

	task automatic report(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	task automatic push(input kind_t k, input logic [7:0] d, input logic me, input err_t e);
		res_t r;
		r.kind = k;
		r.data_byte = d;
		r.message_end = me;
		r.last = 1'b0;
		r.error_code = e;
		burst = {burst, r};
	endtask

	function automatic logic data_frame();
		return p_op == OP_TEXT || p_op == OP_BIN || (p_op == OP_CONT && p_inmsg);
	endfunction

	task automatic fail_with(input err_t e);
		p_err = 1'b1;
		p_phase = PH_HALT;
		push(KIND_ERROR, 8'h00, 1'b0, e);
	endtask

	task automatic finish_header();
		if (p_op == OP_CLOSE) begin
			fail_with(ERR_CLOSE);
			return;
		end
		if (p_op == OP_TEXT || p_op == OP_BIN) begin
			if (p_inmsg)
				push(KIND_DISCARD, 8'h00, 1'b0, ERR_NONE);
			p_msg = '0;
			p_inmsg = 1'b1;
		end
		if (p_op == OP_PING) begin
			push(KIND_TX, PONG_HDR0, 1'b0, ERR_NONE);
			push(KIND_TX, MASK_BIT | {1'b0, p_len[6:0]}, 1'b0, ERR_NONE);
			repeat (4) push(KIND_TX, 8'h00, 1'b0, ERR_NONE);
		end
		if (p_len == 0) begin
			if (data_frame() && p_fin) begin
				push(KIND_EMPTY_END, 8'h00, 1'b0, ERR_NONE);
				p_inmsg = 1'b0;
				p_msg = '0;
			end
			p_phase = PH_HDR0;
		end else begin
			p_pos = '0;
			p_phase = PH_PAYLOAD;
		end
	endtask

	task automatic length_done();
		logic [64:0] sum;
		sum = {1'b0, p_len} + p_msg;
		if (p_len > p_limit || sum > p_limit) begin
			fail_with(ERR_LENGTH);
			return;
		end
		p_mask = '0;
		if (p_maskp) begin
			p_cnt = 3'd4;
			p_phase = PH_MASK;
		end else
			finish_header();
	endtask

	task automatic predict_byte(input req_t rq);
		logic [7:0] b;
		logic [1:0] k;
		logic [7:0] v;
		logic fb;
		b = rq.rx_byte;
		burst.delete();
		if (p_err || p_phase == PH_HALT)
			return;
		if (rq.mode)
			fail_with(ERR_LINK);
		else begin
			case (p_phase)
				PH_HDR0: begin
					p_fin = b[7];
					p_op = b[3:0];
					p_phase = PH_HDR1;
				end
				PH_HDR1: begin
					p_maskp = b[7];
					p_len = '0;
					if (b[6:0] == LEN_EXT16) begin
						p_cnt = 3'd2;
						p_phase = PH_EXT;
					end else if (b[6:0] == LEN_EXT64) begin
						p_cnt = 3'd0;
						p_phase = PH_EXT;
					end else begin
						p_len = {57'd0, b[6:0]};
						length_done();
					end
				end
				PH_EXT: begin
					p_len = {p_len[55:0], b};
					p_cnt = p_cnt - 3'd1;
					if (p_cnt == 0)
						length_done();
				end
				PH_MASK: begin
					p_mask = {p_mask[23:0], b};
					p_cnt = p_cnt - 3'd1;
					if (p_cnt == 0)
						finish_header();
				end
				default: begin
					k = p_pos[1:0];
					v = b ^ p_mask[31 - 8 * k -: 8];
					fb = (p_pos + 1 == p_len);
					if (data_frame()) begin
						p_msg = p_msg + 1'b1;
						push(KIND_PAYLOAD, v, fb && p_fin, ERR_NONE);
						if (fb && p_fin) begin
							p_inmsg = 1'b0;
							p_msg = '0;
						end
					end else if (p_op == OP_PING)
						push(KIND_TX, v, 1'b0, ERR_NONE);
					p_pos = p_pos + 1;
					if (fb)
						p_phase = PH_HDR0;
				end
			endcase
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			want_q = {want_q, burst[i]};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_limit = LIM_RESET;
			p_phase = PH_HDR0;
			p_cnt = '0;
			p_fin = 1'b0;
			p_op = '0;
			p_maskp = 1'b0;
			p_len = '0;
			p_mask = '0;
			p_pos = '0;
			p_msg = '0;
			p_inmsg = 1'b0;
			p_err = 1'b0;
			fail_count = 0;
			want_q.delete();
		end else begin
			if (cfg_we)
				p_limit = cfg_data;
			if (in_valid && !in_stall)
				predict_byte(in_req);
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0)
					report($sformatf("unexpected result %h", out_res));
				else begin
					res_t w;
					w = want_q.pop_front();
					if (out_res.kind != w.kind)
						report($sformatf("kind %0d want %0d", out_res.kind, w.kind));
					if (out_res.data_byte != w.data_byte)
						report($sformatf("data %h want %h", out_res.data_byte, w.data_byte));
					if (out_res.message_end != w.message_end)
						report($sformatf("message_end %b want %b", out_res.message_end,
							w.message_end));
					if (out_res.last != w.last)
						report($sformatf("last %b want %b", out_res.last, w.last));
					if (out_res.error_code != w.error_code)
						report($sformatf("error_code %0d want %0d", out_res.error_code,
							w.error_code));
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ tb/websocket_frame_deframer_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module websocket_frame_deframer_tb;
	import wsdf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_req = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	res_t out_res;
	logic cfg_we = 1'b0;
	logic [LIM_W-1:0] cfg_data = '0;
	int fail_count;
	int pending;
	int cycles = 0;
	logic quiet = 1'b0;
	logic hold_go = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	logic [LIM_W-1:0] cur_limit = LIM_RESET;

	localparam int CYCLE_LIMIT = 200000;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	websocket_frame_deframer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_res(out_res),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	websocket_frame_deframer_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_res(out_res),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold when requested
	always @(posedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_left <= 59;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= int'($urandom_range(0, 2));
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	task automatic send(input logic md, input logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req.mode <= md;
		in_req.rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIM_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_limit = v;
	endtask

	// one frame; len coded as 7-bit, 16-bit or 64-bit per ext
	task automatic frame(input logic fin, input logic [3:0] op, input logic msk,
			input int len, input int ext);
		logic [31:0] key;
		key = $urandom;
		send(1'b0, {fin, $urandom_range(0, 7) == 0 ? 3'b101 : 3'b000, op});
		if (ext == 0)
			send(1'b0, {msk, len[6:0]});
		else if (ext == 1) begin
			send(1'b0, {msk, LEN_EXT16});
			send(1'b0, len[15:8]);
			send(1'b0, len[7:0]);
		end else begin
			send(1'b0, {msk, LEN_EXT64});
			for (int i = 7; i >= 0; i--)
				send(1'b0, i >= 4 ? 8'h00 : len[8 * i +: 8]);
		end
		if (msk)
			for (int i = 3; i >= 0; i--)
				send(1'b0, key[8 * i +: 8]);
		for (int i = 0; i < len; i++)
			send(1'b0, 8'($urandom));
	endtask

	task automatic restart();
		idle_wait();
		// error latches; reset is used once, so a closed link ends a phase
	endtask

	initial begin
		int r;
		logic [3:0] rop;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		frame(1'b1, OP_TEXT, 1'b1, 3, 0);
		frame(1'b0, OP_BIN, 1'b0, 2, 0);
		frame(1'b1, OP_CONT, 1'b1, 0, 0);
		frame(1'b1, OP_PING, 1'b1, 2, 0);
		frame(1'b1, 4'hA, 1'b0, 1, 0);
		frame(1'b1, OP_CONT, 1'b0, 1, 0);
		frame(1'b0, OP_TEXT, 1'b0, 1, 0);
		frame(1'b1, OP_TEXT, 1'b1, 1, 1);
		frame(1'b1, OP_BIN, 1'b0, 1, 2);
		idle_wait();
		write_limit(25'h1FFFFFF);
		frame(1'b1, OP_TEXT, 1'b0, 2, 1);
		idle_wait();
		write_limit(25'd1);
		frame(1'b1, OP_TEXT, 1'b0, 1, 0);
		idle_wait();
		write_limit(LIM_RESET);

		// long receiver hold while bytes keep coming
		hold_go <= 1'b1;
		frame(1'b1, OP_PING, 1'b0, 5, 0);

		// random frames
		for (int n = 0; n < 5; n++) begin
			if (n == 1) begin
				idle_wait();
				write_limit(25'd20);
			end
			if (n == 3) begin
				idle_wait();
				write_limit(LIM_RESET);
			end
			if (n == 4) begin
				idle_wait();
				quiet = 1'b1;
			end
			r = $urandom_range(0, 9);
			case (r)
				0, 1, 2: frame(1'($urandom), OP_TEXT, 1'($urandom), $urandom_range(0, 6), 0);
				3: frame(1'($urandom), OP_BIN, 1'($urandom), $urandom_range(0, 8),
					$urandom_range(0, 2));
				4, 5: frame(1'($urandom), OP_CONT, 1'($urandom), $urandom_range(0, 5), 0);
				6: frame(1'b1, OP_PING, 1'($urandom), $urandom_range(0, 4), 0);
				7: begin
					rop = 4'($urandom);
					if (rop == OP_CLOSE)
						rop = 4'hB;
					frame(1'($urandom), rop, 1'($urandom), $urandom_range(0, 3), 0);
				end
				default: frame(1'b1, 4'hA, 1'($urandom), $urandom_range(0, 3), 0);
			endcase
		end

		// length over limit, then link closed, then close (all latched after the first)
		idle_wait();
		write_limit(25'd0);
		send(1'b0, {1'b1, 3'b000, OP_TEXT});
		send(1'b0, 8'h05);
		send(1'b0, 8'hFF);
		send(1'b1, 8'hFF);
		send(1'b0, {1'b1, 3'b000, OP_CLOSE});
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/wsdf_pkg.sv
rtl/core/websocket_frame_deframer.sv
tb/websocket_frame_deframer_chk.sv
tb/websocket_frame_deframer_tb.sv
